// ===== design/tlac_pkg.sv =====
// ----------------------------------------------------------------------------
// tlac_pkg: shared types and constants for transpose_list_access_cost
// Table geometry, field widths, controller states and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tlac_pkg;

	// List depth; a power of two so that the slot of a value is a truncation
	localparam int ENTRIES = 1024;
	localparam int SLOT_W  = $clog2(ENTRIES);
	localparam int VAL_W   = 11;
	localparam int TOTAL_W = 48;
	localparam int EXT_W   = (SLOT_W > VAL_W) ? SLOT_W : VAL_W;

	// Divider step counter, counts VAL_W quotient bits
	localparam int DIV_CNT_W = $clog2(VAL_W + 1);

	localparam int IN_DATA_W  = ((2 * VAL_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((2 * VAL_W + TOTAL_W + 7) / 8) * 8;

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_ACCESS = 1'b1;

	typedef logic [VAL_W-1:0]   val_t;
	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [TOTAL_W-1:0] total_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_A_RDP,
		ST_A_POS,
		ST_A_CHK,
		ST_A_RDA,
		ST_A_GETY,
		ST_A_WRH,
		ST_A_WRA,
		ST_A_DEC,
		ST_A_RDB,
		ST_A_INC,
		ST_A_WAIT,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic capture;
		logic load_wr;
		logic pos_rd_item;
		logic p_capture;
		logic itm_rd_here;
		logic itm_rd_ahead;
		logic x_capture;
		logic y_capture;
		logic itm_wr_here;
		logic itm_wr_ahead;
		logic pos_rd_x;
		logic pos_wr_dec;
		logic pos_rd_y;
		logic pos_wr_inc;
		logic result;
	} cmd_t;

	typedef struct packed {
		logic is_load;
		logic p_gt1;
		logic div_busy;
	} sts_t;

	// Value v maps to slot (v - 1) mod ENTRIES
	function automatic slot_t slot_of(input val_t v);
		logic [EXT_W-1:0] t;
		t = EXT_W'(v) - EXT_W'(1);
		return t[SLOT_W-1:0];
	endfunction

endpackage

// ===== design/transpose_list_access_cost.sv =====
// ----------------------------------------------------------------------------
// transpose_list_access_cost: self-organizing list with paged access cost
// Loads place items in the list; accesses charge ceil(position / page size),
// keep a saturating total and move the item one place toward the front.
// ----------------------------------------------------------------------------
//  channel  direction  transaction carries
//  s_*      in         request: kind in tuser, item and load position in tdata
//  m_*      out        result: found position, page cost, running total
//  cfg_*    in         page size write
//
// A load goes from acceptance through ST_A_RDP and ST_LOAD to ST_RESULT; an
// access waits in ST_A_WAIT for the bit-serial cost divider (one quotient bit
// per cycle), which runs alongside the table reads and writes of the transpose.
// One request is in flight at a time; a finished result waits in the output
// register while the next request is taken. The tables need no clearing after
// reset; the running total resets to zero and the page size to one.
module transpose_list_access_cost (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [10:0] item_id, [21:11] load_position, rest zero
	input  logic [tlac_pkg::IN_DATA_W-1:0]     s_tdata,
	// [0] req_type
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [10:0] found_position, [21:11] page_cost, [69:22] total_cost, rest zero
	output logic [tlac_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tlac_pkg::VAL_W-1:0]         cfg_data
);

	tlac_pkg::cmd_t   cmd;
	tlac_pkg::sts_t   sts;
	tlac_pkg::val_t   found;
	tlac_pkg::val_t   cost;
	tlac_pkg::total_t total;

	assign cfg_ready = 1'b1;

	tlac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	tlac_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.in_req_type       (s_tuser),
		.in_item_id        (s_tdata[tlac_pkg::VAL_W-1:0]),
		.in_load_position  (s_tdata[2*tlac_pkg::VAL_W-1:tlac_pkg::VAL_W]),
		.cfg_we            (cfg_valid & cfg_ready),
		.cfg_page_size     (cfg_data),
		.out_found_position(found),
		.out_page_cost     (cost),
		.out_total_cost    (total)
	);

	assign m_tdata = tlac_pkg::OUT_DATA_W'({total, cost, found});

endmodule

// ===== design/tlac_ram.sv =====
// ----------------------------------------------------------------------------
// tlac_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tlac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/tlac_div.sv =====
// ----------------------------------------------------------------------------
// tlac_div: ceiling divider
// Restoring division, one quotient bit per cycle; returns ceil(num / den),
// a zero divisor counts as one.
// ----------------------------------------------------------------------------
module tlac_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  tlac_pkg::val_t num,
	input  tlac_pkg::val_t den,
	output logic          busy,
	output tlac_pkg::val_t quo
);

	logic [tlac_pkg::DIV_CNT_W-1:0] cnt_q;
	tlac_pkg::val_t         rem_q;
	tlac_pkg::val_t         quo_q;
	tlac_pkg::val_t         den_q;
	logic [tlac_pkg::VAL_W:0] sh;
	logic                   fits;

	assign sh   = {rem_q, quo_q[tlac_pkg::VAL_W-1]};
	assign fits = sh >= {1'b0, den_q};
	assign busy = cnt_q != '0;
	assign quo  = quo_q + tlac_pkg::VAL_W'(rem_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= tlac_pkg::DIV_CNT_W'(tlac_pkg::VAL_W);
		end else if (busy) begin
			cnt_q <= cnt_q - tlac_pkg::DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= (den == '0) ? tlac_pkg::VAL_W'(1) : den;
		end else if (busy) begin
			if (fits) begin
				rem_q <= tlac_pkg::VAL_W'(sh - {1'b0, den_q});
				quo_q <= {quo_q[tlac_pkg::VAL_W-2:0], 1'b1};
			end else begin
				rem_q <= sh[tlac_pkg::VAL_W-1:0];
				quo_q <= {quo_q[tlac_pkg::VAL_W-2:0], 1'b0};
			end
		end
	end

endmodule

// ===== design/tlac_dp.sv =====
// ----------------------------------------------------------------------------
// tlac_dp: datapath
// Forward and inverse tables, request registers, cost divider, running
// total and the output register.
// ----------------------------------------------------------------------------
module tlac_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tlac_pkg::cmd_t         cmd,
	output tlac_pkg::sts_t         sts,
	input  logic                   in_req_type,
	input  tlac_pkg::val_t         in_item_id,
	input  tlac_pkg::val_t         in_load_position,
	input  logic                   cfg_we,
	input  tlac_pkg::val_t         cfg_page_size,
	output tlac_pkg::val_t         out_found_position,
	output tlac_pkg::val_t         out_page_cost,
	output tlac_pkg::total_t       out_total_cost
);

	logic                req_q;
	tlac_pkg::val_t      item_q;
	tlac_pkg::val_t      lpos_q;
	tlac_pkg::val_t      p_q;
	tlac_pkg::val_t      x_q;
	tlac_pkg::val_t      y_q;
	tlac_pkg::val_t      page_size_q;
	tlac_pkg::total_t    total_q;
	tlac_pkg::val_t      found_q;
	tlac_pkg::val_t      cost_q;
	tlac_pkg::total_t    out_total_q;

	logic                itm_we;
	tlac_pkg::slot_t     itm_waddr;
	tlac_pkg::val_t      itm_wdata;
	logic                itm_re;
	tlac_pkg::slot_t     itm_raddr;
	tlac_pkg::val_t      itm_rdata;

	logic                pos_we;
	tlac_pkg::slot_t     pos_waddr;
	tlac_pkg::val_t      pos_wdata;
	logic                pos_re;
	tlac_pkg::slot_t     pos_raddr;
	tlac_pkg::val_t      pos_rdata;

	logic                div_busy;
	tlac_pkg::val_t      div_quo;
	logic [tlac_pkg::TOTAL_W:0] sum;
	tlac_pkg::total_t    total_sat;
	tlac_pkg::slot_t     here_slot;
	tlac_pkg::slot_t     ahead_slot;

	assign here_slot  = tlac_pkg::slot_of(p_q);
	assign ahead_slot = tlac_pkg::slot_of(p_q - tlac_pkg::VAL_W'(1));

	// Forward table: position -> item
	assign itm_we    = cmd.load_wr | cmd.itm_wr_here | cmd.itm_wr_ahead;
	assign itm_waddr = cmd.load_wr ? tlac_pkg::slot_of(lpos_q) :
			cmd.itm_wr_here ? here_slot : ahead_slot;
	assign itm_wdata = cmd.load_wr ? item_q : cmd.itm_wr_here ? y_q : x_q;
	assign itm_re    = cmd.itm_rd_here | cmd.itm_rd_ahead;
	assign itm_raddr = cmd.itm_rd_here ? here_slot : ahead_slot;

	// Inverse table: item -> position
	assign pos_we    = cmd.load_wr | cmd.pos_wr_dec | cmd.pos_wr_inc;
	assign pos_waddr = cmd.load_wr ? tlac_pkg::slot_of(item_q) :
			cmd.pos_wr_dec ? tlac_pkg::slot_of(x_q) : tlac_pkg::slot_of(y_q);
	assign pos_wdata = cmd.load_wr ? lpos_q :
			cmd.pos_wr_dec ? pos_rdata - tlac_pkg::VAL_W'(1) :
			pos_rdata + tlac_pkg::VAL_W'(1);
	assign pos_re    = cmd.pos_rd_item | cmd.pos_rd_x | cmd.pos_rd_y;
	assign pos_raddr = cmd.pos_rd_item ? tlac_pkg::slot_of(item_q) :
			cmd.pos_rd_x ? tlac_pkg::slot_of(x_q) : tlac_pkg::slot_of(y_q);

	tlac_ram #(
		.WIDTH(tlac_pkg::VAL_W),
		.DEPTH(tlac_pkg::ENTRIES)
	) u_item_ram (
		.clk  (clk),
		.we   (itm_we),
		.waddr(itm_waddr),
		.wdata(itm_wdata),
		.re   (itm_re),
		.raddr(itm_raddr),
		.rdata(itm_rdata)
	);

	tlac_ram #(
		.WIDTH(tlac_pkg::VAL_W),
		.DEPTH(tlac_pkg::ENTRIES)
	) u_pos_ram (
		.clk  (clk),
		.we   (pos_we),
		.waddr(pos_waddr),
		.wdata(pos_wdata),
		.re   (pos_re),
		.raddr(pos_raddr),
		.rdata(pos_rdata)
	);

	tlac_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.p_capture),
		.num   (pos_rdata),
		.den   (page_size_q),
		.busy  (div_busy),
		.quo   (div_quo)
	);

	assign sum       = {1'b0, total_q} + (tlac_pkg::TOTAL_W + 1)'(div_quo);
	assign total_sat = sum[tlac_pkg::TOTAL_W] ? '1 : sum[tlac_pkg::TOTAL_W-1:0];

	assign sts.is_load  = req_q == tlac_pkg::REQ_LOAD;
	assign sts.p_gt1    = p_q > tlac_pkg::VAL_W'(1);
	assign sts.div_busy = div_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q <= tlac_pkg::VAL_W'(1);
			total_q     <= '0;
		end else begin
			if (cfg_we) begin
				page_size_q <= cfg_page_size;
			end
			if (cmd.result && req_q == tlac_pkg::REQ_ACCESS) begin
				total_q <= total_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= in_req_type;
			item_q <= in_item_id;
			lpos_q <= in_load_position;
		end
		if (cmd.p_capture) begin
			p_q <= pos_rdata;
		end
		if (cmd.x_capture) begin
			x_q <= itm_rdata;
		end
		if (cmd.y_capture) begin
			y_q <= itm_rdata;
		end
		if (cmd.result) begin
			if (req_q == tlac_pkg::REQ_LOAD) begin
				found_q     <= lpos_q;
				cost_q      <= '0;
				out_total_q <= total_q;
			end else begin
				found_q     <= p_q;
				cost_q      <= div_quo;
				out_total_q <= total_sat;
			end
		end
	end

	assign out_found_position = found_q;
	assign out_page_cost      = cost_q;
	assign out_total_cost     = out_total_q;

endmodule

// ===== design/tlac_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlac_ctrl: controller
// Sequences table reads and writes for loads and transposes, waits for the
// divider and hands results to the output register.
// ----------------------------------------------------------------------------
module tlac_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output tlac_pkg::cmd_t cmd,
	input  tlac_pkg::sts_t sts
);

	tlac_pkg::state_t state_q;
	tlac_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tlac_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = tlac_pkg::ST_A_RDP;
				end
			end
			tlac_pkg::ST_A_RDP: begin
				// request registers are loaded; loads branch off here
				state_d = sts.is_load ? tlac_pkg::ST_LOAD : tlac_pkg::ST_A_POS;
			end
			tlac_pkg::ST_LOAD:   state_d = tlac_pkg::ST_RESULT;
			tlac_pkg::ST_A_POS:  state_d = tlac_pkg::ST_A_CHK;
			tlac_pkg::ST_A_CHK: begin
				state_d = sts.p_gt1 ? tlac_pkg::ST_A_RDA : tlac_pkg::ST_A_WAIT;
			end
			tlac_pkg::ST_A_RDA:  state_d = tlac_pkg::ST_A_GETY;
			tlac_pkg::ST_A_GETY: state_d = tlac_pkg::ST_A_WRH;
			tlac_pkg::ST_A_WRH:  state_d = tlac_pkg::ST_A_WRA;
			tlac_pkg::ST_A_WRA:  state_d = tlac_pkg::ST_A_DEC;
			tlac_pkg::ST_A_DEC:  state_d = tlac_pkg::ST_A_RDB;
			tlac_pkg::ST_A_RDB:  state_d = tlac_pkg::ST_A_INC;
			tlac_pkg::ST_A_INC:  state_d = tlac_pkg::ST_A_WAIT;
			tlac_pkg::ST_A_WAIT: begin
				if (!sts.div_busy) begin
					state_d = tlac_pkg::ST_RESULT;
				end
			end
			tlac_pkg::ST_RESULT: begin
				if (out_free) begin
					state_d = tlac_pkg::ST_IDLE;
				end
			end
			default: state_d = tlac_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			tlac_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			tlac_pkg::ST_A_RDP: cmd.pos_rd_item = !sts.is_load;
			tlac_pkg::ST_LOAD:  cmd.load_wr = 1'b1;
			tlac_pkg::ST_A_POS: cmd.p_capture = 1'b1;
			tlac_pkg::ST_A_CHK: cmd.itm_rd_here = sts.p_gt1;
			tlac_pkg::ST_A_RDA: begin
				cmd.x_capture    = 1'b1;
				cmd.itm_rd_ahead = 1'b1;
			end
			tlac_pkg::ST_A_GETY: cmd.y_capture = 1'b1;
			tlac_pkg::ST_A_WRH:  cmd.itm_wr_here = 1'b1;
			tlac_pkg::ST_A_WRA: begin
				cmd.itm_wr_ahead = 1'b1;
				cmd.pos_rd_x     = 1'b1;
			end
			tlac_pkg::ST_A_DEC: cmd.pos_wr_dec = 1'b1;
			tlac_pkg::ST_A_RDB: cmd.pos_rd_y = 1'b1;
			tlac_pkg::ST_A_INC: cmd.pos_wr_inc = 1'b1;
			tlac_pkg::ST_A_WAIT: begin
			end
			tlac_pkg::ST_RESULT: cmd.result = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tlac_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tlac_pkg::ST_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== verif/transpose_list_access_cost_tb.sv =====
// ----------------------------------------------------------------------------
// transpose_list_access_cost_tb: self-checking bench for the transpose list
// Drives load and access requests over the stream ports and mirrors the list
// tables, the paged cost and the running total in a scoreboard. Each result
// is compared field by field. Sweeps several page sizes, idle patterns and a
// long output backpressure stretch.
// ----------------------------------------------------------------------------
module transpose_list_access_cost_tb;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 24;
	localparam int MAX_SEQ      = 160;
	localparam tlac_pkg::total_t TOTAL_CAP = '1;

	typedef struct {
		tlac_pkg::val_t   found;
		tlac_pkg::val_t   cost;
		tlac_pkg::total_t total;
	} list_result_t;

	class list_cost_scoreboard;
		tlac_pkg::val_t   item_table[tlac_pkg::ENTRIES];
		tlac_pkg::val_t   pos_table[tlac_pkg::ENTRIES];
		bit               item_written[tlac_pkg::ENTRIES];
		bit               pos_written[tlac_pkg::ENTRIES];
		tlac_pkg::total_t running_total;
		tlac_pkg::val_t   page_size;
		list_result_t     pending_results[$];
		int               errors;
		int               checked;
		int               loads;
		int               accesses;
		int               transposes;

		function new();
			running_total = '0;
			page_size = tlac_pkg::val_t'(1);
			errors = 0;
			checked = 0;
			loads = 0;
			accesses = 0;
			transposes = 0;
		endfunction

		// value v lives in slot (v - 1) mod ENTRIES; 11-bit wrap keeps that exact
		function int slot(tlac_pkg::val_t v);
			tlac_pkg::val_t t;
			t = v - tlac_pkg::val_t'(1);
			return int'(t) % tlac_pkg::ENTRIES;
		endfunction

		// true when an access would only touch table entries already written
		function bit can_access(tlac_pkg::val_t item);
			int             s;
			tlac_pkg::val_t p;
			tlac_pkg::val_t here_item;
			tlac_pkg::val_t ahead_item;
			s = slot(item);
			if (!pos_written[s])
				return 0;
			p = pos_table[s];
			if (p <= 1)
				return 1;
			if (!item_written[slot(p)] || !item_written[slot(p - tlac_pkg::val_t'(1))])
				return 0;
			here_item = item_table[slot(p)];
			ahead_item = item_table[slot(p - tlac_pkg::val_t'(1))];
			return pos_written[slot(here_item)] && pos_written[slot(ahead_item)];
		endfunction

		function void note_request(logic req, tlac_pkg::val_t item, tlac_pkg::val_t lpos);
			list_result_t   r;
			tlac_pkg::val_t p;
			tlac_pkg::val_t moved;
			int             divisor;
			int             cost;
			int             here;
			int             ahead;
			int             s;
			if (req == tlac_pkg::REQ_LOAD) begin
				item_table[slot(lpos)] = item;
				item_written[slot(lpos)] = 1'b1;
				pos_table[slot(item)] = lpos;
				pos_written[slot(item)] = 1'b1;
				r.found = lpos;
				r.cost = '0;
				r.total = running_total;
				loads++;
			end else begin
				p = pos_table[slot(item)];
				divisor = (page_size == 0) ? 1 : int'(page_size);
				cost = (int'(p) + divisor - 1) / divisor;
				if (running_total > TOTAL_CAP - tlac_pkg::total_t'(cost))
					running_total = TOTAL_CAP;
				else
					running_total = running_total + tlac_pkg::total_t'(cost);
				if (p > 1) begin
					here = slot(p);
					ahead = slot(p - tlac_pkg::val_t'(1));
					moved = item_table[here];
					item_table[here] = item_table[ahead];
					item_table[ahead] = moved;
					s = slot(item_table[ahead]);
					pos_table[s] = pos_table[s] - tlac_pkg::val_t'(1);
					s = slot(item_table[here]);
					pos_table[s] = pos_table[s] + tlac_pkg::val_t'(1);
					transposes++;
				end
				r.found = p;
				r.cost = tlac_pkg::val_t'(cost);
				r.total = running_total;
				accesses++;
			end
			pending_results = {pending_results, r};
		endfunction

		function void check_result(logic [tlac_pkg::OUT_DATA_W-1:0] d);
			list_result_t     want;
			tlac_pkg::val_t   found;
			tlac_pkg::val_t   cost;
			tlac_pkg::total_t total;
			found = d[tlac_pkg::VAL_W-1:0];
			cost = d[2*tlac_pkg::VAL_W-1:tlac_pkg::VAL_W];
			total = d[2*tlac_pkg::VAL_W+tlac_pkg::TOTAL_W-1:2*tlac_pkg::VAL_W];
			checked++;
			if (pending_results.size() == 0) begin
				$error("unexpected result: found_position %0d page_cost %0d total_cost %0d",
					found, cost, total);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (found !== want.found) begin
				$error("found_position: expected %0d, actual %0d", want.found, found);
				errors++;
			end
			if (cost !== want.cost) begin
				$error("page_cost: expected %0d, actual %0d", want.cost, cost);
				errors++;
			end
			if (total !== want.total) begin
				$error("total_cost: expected %0d, actual %0d", want.total, total);
				errors++;
			end
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [tlac_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                            s_tuser;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [tlac_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            cfg_valid;
	logic                            cfg_ready;
	tlac_pkg::val_t                  cfg_data;

	list_cost_scoreboard sb;
	int                  tx_idle_pct;
	int                  rx_idle_pct;
	bit                  hold_request;
	int                  cycle_count;

	transpose_list_access_cost DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("cycle limit of %0d reached", CYCLE_LIMIT);
		$display("[transpose_list_access_cost] ERROR");
		$finish;
	end

	// result side: check each accepted transaction, then pick next tready
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall_left = 400;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic send_request(input logic req, input tlac_pkg::val_t item,
			input tlac_pkg::val_t lpos);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= tlac_pkg::IN_DATA_W'({lpos, item});
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_request(req, item, lpos);
	endtask

	task automatic access_item(input tlac_pkg::val_t item);
		if (sb.can_access(item))
			send_request(tlac_pkg::REQ_ACCESS, item,
				tlac_pkg::val_t'($urandom_range(0, 2047)));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_page(input tlac_pkg::val_t v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		sb.page_size = v;
	endtask

	// mostly: load a shuffled block of items, then hammer it with accesses
	task automatic run_random(input int count);
		tlac_pkg::val_t seq_items[MAX_SEQ];
		tlac_pkg::val_t seq_pos[MAX_SEQ];
		tlac_pkg::val_t t;
		int   sent;
		int   n;
		int   loaded;
		int   pstart;
		int   istart;
		int   r;
		int   i;
		int   j;
		int   tries;
		int   reps;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(9) == 0) begin
				send_request(tlac_pkg::REQ_LOAD, tlac_pkg::val_t'($urandom_range(0, 2047)),
					tlac_pkg::val_t'($urandom_range(0, 2047)));
				sent++;
			end else begin
				r = $urandom_range(99);
				if (r < 70)
					n = $urandom_range(2, 12);
				else if (r < 95)
					n = $urandom_range(13, 64);
				else
					n = $urandom_range(65, MAX_SEQ);
				pstart = ($urandom_range(3) != 0) ? 1 :
					$urandom_range(1, tlac_pkg::ENTRIES + 1 - n);
				istart = $urandom_range(1, tlac_pkg::ENTRIES + 1 - n);
				for (i = 0; i < n; i++) begin
					seq_items[i] = tlac_pkg::val_t'(istart + i);
					// alias id that selects the same slot
					if ($urandom_range(7) == 0 && istart + i + tlac_pkg::ENTRIES <= 2047)
						seq_items[i] = tlac_pkg::val_t'(istart + i + tlac_pkg::ENTRIES);
					seq_pos[i] = tlac_pkg::val_t'(pstart + i);
				end
				for (i = n - 1; i > 0; i--) begin
					j = $urandom_range(i);
					t = seq_pos[i];
					seq_pos[i] = seq_pos[j];
					seq_pos[j] = t;
				end
				// now and then a sequence is cut short
				loaded = ($urandom_range(9) == 0) ? $urandom_range(1, n) : n;
				for (i = 0; i < loaded && sent < count; i++) begin
					send_request(tlac_pkg::REQ_LOAD, seq_items[i], seq_pos[i]);
					sent++;
				end
				reps = (n > 64) ? n : n * $urandom_range(2, 4);
				for (i = 0; i < reps && sent < count; i++) begin
					for (tries = 0; tries < 8; tries++) begin
						t = seq_items[$urandom_range(loaded - 1)];
						if (sb.can_access(t))
							break;
					end
					if (tries < 8) begin
						send_request(tlac_pkg::REQ_ACCESS, t,
							tlac_pkg::val_t'($urandom_range(0, 2047)));
						sent++;
					end
				end
			end
		end
	endtask

	initial begin
		tlac_pkg::val_t page_steps[6];
		int   ph;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= tlac_pkg::REQ_LOAD;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		hold_request = 1'b0;
		tx_idle_pct = 33;
		rx_idle_pct = 62;
		sb = new();
		// first phase runs on the reset page size
		page_steps[0] = tlac_pkg::val_t'(1);
		page_steps[1] = tlac_pkg::val_t'(1024);
		page_steps[2] = tlac_pkg::val_t'(0);
		page_steps[3] = tlac_pkg::val_t'(2047);
		page_steps[4] = tlac_pkg::val_t'(3);
		page_steps[5] = tlac_pkg::val_t'(7);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short list: front item, repeated moves toward the front
		send_request(tlac_pkg::REQ_LOAD, tlac_pkg::val_t'(1), tlac_pkg::val_t'(1));
		send_request(tlac_pkg::REQ_LOAD, tlac_pkg::val_t'(2), tlac_pkg::val_t'(2));
		send_request(tlac_pkg::REQ_LOAD, tlac_pkg::val_t'(3), tlac_pkg::val_t'(3));
		access_item(tlac_pkg::val_t'(1));
		access_item(tlac_pkg::val_t'(3));
		access_item(tlac_pkg::val_t'(3));
		access_item(tlac_pkg::val_t'(3));
		access_item(tlac_pkg::val_t'(2));
		// top of the nominal range
		send_request(tlac_pkg::REQ_LOAD, tlac_pkg::val_t'(1022), tlac_pkg::val_t'(1022));
		send_request(tlac_pkg::REQ_LOAD, tlac_pkg::val_t'(1023), tlac_pkg::val_t'(1023));
		send_request(tlac_pkg::REQ_LOAD, tlac_pkg::val_t'(1024), tlac_pkg::val_t'(1024));
		access_item(tlac_pkg::val_t'(1024));
		access_item(tlac_pkg::val_t'(1023));
		// all-ones values wrap onto lower slots
		send_request(tlac_pkg::REQ_LOAD, tlac_pkg::val_t'(2047), tlac_pkg::val_t'(2047));
		access_item(tlac_pkg::val_t'(2047));
		// zero selects the last slot; position zero costs nothing
		send_request(tlac_pkg::REQ_LOAD, tlac_pkg::val_t'(0), tlac_pkg::val_t'(0));
		access_item(tlac_pkg::val_t'(0));
		access_item(tlac_pkg::val_t'(1024));

		for (ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				drain();
				write_page(page_steps[ph]);
			end
			tx_idle_pct = (ph < 2) ? 33 : (ph < 4) ? 62 : 0;
			rx_idle_pct = (ph < 2) ? 62 : (ph < 4) ? 33 : 0;
			// long output stall while requests keep coming
			if (ph == 4)
				hold_request = 1'b1;
			run_random(245);
		end
		drain();

		$display("run covered %0d loads and %0d accesses (%0d transposes), %0d results checked",
			sb.loads, sb.accesses, sb.transposes, sb.checked);
		$display("page sizes 1, 1024, 0, 2047, 3 and 7; running total ended at %0d",
			sb.running_total);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("[transpose_list_access_cost] OK");
		else
			$display("[transpose_list_access_cost] ERROR");
		$finish;
	end

endmodule
